>>> hdl/slmfd_pkg.sv
// ----------------------------------------------------------------------------
// slmfd_pkg
// Shared types, command codes and glyph ROMs for the scrolling floor display.
// ----------------------------------------------------------------------------
package slmfd_pkg;

  localparam int unsigned CHAR_COUNT     = 2;
  localparam logic [15:0] PERIOD_RESET   = 16'd50;
  localparam logic [3:0]  FLOOR_RESET    = 4'd1;
  localparam logic [3:0]  DIGIT_COUNT    = 4'd6;
  localparam logic [15:0] TICK_MAX       = 16'hFFFF;
  localparam logic [7:0]  COLUMNS_OFF    = 8'hFF;

  typedef enum logic [1:0] {
    CMD_SET_FLOOR = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_SCAN      = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] floor;
  } item_t;

  typedef struct packed {
    logic [7:0] column_drive;
    logic [7:0] row_drive;
    logic       going_down;
  } result_t;

  localparam logic [0:5][0:7][7:0] DIGIT_ROM = {
    {8'h70, 8'h88, 8'h98, 8'hA8, 8'hC8, 8'h88, 8'h70, 8'h00},
    {8'h40, 8'hC0, 8'h40, 8'h40, 8'h40, 8'h40, 8'hE0, 8'h00},
    {8'h70, 8'h88, 8'h08, 8'h10, 8'h20, 8'h40, 8'hF8, 8'h00},
    {8'hF8, 8'h10, 8'h20, 8'h10, 8'h08, 8'h88, 8'h70, 8'h00},
    {8'h10, 8'h30, 8'h50, 8'h90, 8'hF8, 8'h10, 8'h10, 8'h00},
    {8'hF8, 8'h80, 8'hF0, 8'h08, 8'h08, 8'h88, 8'h70, 8'h00}
  };

  localparam logic [0:1][0:7][7:0] ARROW_ROM = {
    {8'h18, 8'h18, 8'h3C, 8'h7E, 8'h18, 8'h18, 8'h18, 8'h18},
    {8'h18, 8'h18, 8'h18, 8'h18, 8'h7E, 8'h3C, 8'h18, 8'h18}
  };

endpackage

>>> hdl/scrolling_led_matrix_floor_display_top.sv
// ----------------------------------------------------------------------------
// scrolling_led_matrix_floor_display_top
// 8x8 LED matrix driver showing a direction arrow and a scrolling floor digit.
//
//   channel | ports                                       | direction
//   --------+---------------------------------------------+----------
//   in      | in_valid/in_ready, in_command, in_floor     | input
//   out     | out_valid/out_ready, out_column_drive,      | output
//           | out_row_drive, out_going_down               |
//   cfg     | cfg_valid/cfg_ready, cfg_data               | input
//
// One transaction per cycle while the output is not stalled; each one goes
// through the input register, a single pass through the engine, and the result register.
// Synchronous active-low reset; no clearing pass, ready in the first cycle
// out of reset.
// A stalled output holds its result while the input register still takes a
// further transaction.
// ----------------------------------------------------------------------------
module scrolling_led_matrix_floor_display_top #(
  parameter int unsigned CHAR_COUNT = slmfd_pkg::CHAR_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_floor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_column_drive,
  output logic [7:0]  out_row_drive,
  output logic        out_going_down,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import slmfd_pkg::*;

  logic        item_valid;
  item_t       item;
  result_t     res;
  result_t     out_r;
  logic        out_valid_r;
  logic        can_load;
  logic        fire;
  logic [15:0] scroll_period_r;

  assign can_load  = !out_valid_r || out_ready;
  assign fire      = item_valid && can_load;
  assign cfg_ready = 1'b1;

  slmfd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_floor   (in_floor),
    .advance    (can_load),
    .item_valid (item_valid),
    .item       (item)
  );

  slmfd_engine #(
    .CHAR_COUNT (CHAR_COUNT)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (item),
    .scroll_period (scroll_period_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_period_r <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scroll_period_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_load) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column_drive = out_r.column_drive;
  assign out_row_drive    = out_r.row_drive;
  assign out_going_down   = out_r.going_down;

  // a lit row only ever comes with exactly one column driven
  a_scan_one_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_drive != 8'h00) |-> $countones(~out_column_drive) == 1)
    else $error("row drive without a single active column");

  // columns either all off or exactly one on
  a_column_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_column_drive == COLUMNS_OFF) ||
                  ($countones(~out_column_drive) == 1))
    else $error("illegal column pattern");

  // a waiting item in the input register is not lost while the output stalls
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && !can_load |=> item_valid && $stable(item))
    else $error("input register dropped a transaction");

  // a stalled result is not overwritten
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
    else $error("result register overwritten under stall");

endmodule

>>> hdl/slmfd_in_stage.sv
// ----------------------------------------------------------------------------
// slmfd_in_stage
// Input register: captures one transaction and holds it until it is processed.
// ----------------------------------------------------------------------------
module slmfd_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [3:0]           in_floor,
  input  logic                 advance,
  output logic                 item_valid,
  output slmfd_pkg::item_t     item
);
  import slmfd_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.command <= in_command;
      item_r.floor   <= in_floor;
    end
  end

endmodule

>>> hdl/slmfd_engine.sv
// ----------------------------------------------------------------------------
// slmfd_engine
// Display state: floor, glyph slots, scroll position, frame and scan column.
// ----------------------------------------------------------------------------
module slmfd_engine #(
  parameter int unsigned CHAR_COUNT = slmfd_pkg::CHAR_COUNT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  slmfd_pkg::item_t     item,
  input  logic [15:0]          scroll_period,
  output slmfd_pkg::result_t   res
);
  import slmfd_pkg::*;

  localparam logic [1:0] SLOT_WRAP = 2'(CHAR_COUNT + 1);

  logic [3:0]  cur_floor_r, cur_floor_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [2:0]  bit_offset_r, bit_offset_nxt;
  logic [1:0]  slot_index_r, slot_index_nxt;
  logic [2:0]  scan_col_r, scan_col_nxt;
  logic        arrow_down_r, arrow_down_nxt;
  logic [7:0]  slot0_r [8];
  logic [7:0]  slot0_nxt [8];
  logic [7:0]  slot1_r [8];
  logic [7:0]  slot1_nxt [8];
  logic [7:0]  frame_r [8];
  logic [7:0]  frame_nxt [8];

  logic [15:0] tick_inc;
  logic        scroll_due;
  logic [1:0]  s_hi;
  logic [1:0]  si_inc;
  logic        down;
  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic [15:0] pair;

  assign tick_inc   = (tick_count_r != TICK_MAX) ? tick_count_r + 16'd1 : tick_count_r;
  assign scroll_due = (tick_inc >= scroll_period);
  assign s_hi       = slot_index_r + 2'd1;
  assign si_inc     = slot_index_r + 2'd1;
  assign down       = !(cur_floor_r < item.floor);

  always_comb begin
    cur_floor_nxt  = cur_floor_r;
    tick_count_nxt = tick_count_r;
    bit_offset_nxt = bit_offset_r;
    slot_index_nxt = slot_index_r;
    scan_col_nxt   = scan_col_r;
    arrow_down_nxt = arrow_down_r;
    slot0_nxt      = slot0_r;
    slot1_nxt      = slot1_r;
    frame_nxt      = frame_r;
    lo_byte        = 8'h00;
    hi_byte        = 8'h00;
    pair           = 16'h0000;
    res.column_drive = COLUMNS_OFF;
    res.row_drive    = 8'h00;

    case (cmd_t'(item.command))
      CMD_SET_FLOOR: begin
        arrow_down_nxt = down;
        cur_floor_nxt  = item.floor;
        tick_count_nxt = '0;
        for (int j = 0; j < 8; j++) begin
          slot0_nxt[j] = ARROW_ROM[down][j];
          slot1_nxt[j] = (item.floor < DIGIT_COUNT) ? DIGIT_ROM[item.floor[2:0]][j] : 8'h00;
        end
      end
      CMD_TICK: begin
        tick_count_nxt = tick_inc;
        if (scroll_due) begin
          tick_count_nxt = '0;
          for (int k = 0; k < 8; k++) begin
            unique case (slot_index_r)
              2'd0:    lo_byte = slot0_r[k];
              2'd1:    lo_byte = slot1_r[k];
              default: lo_byte = 8'h00;
            endcase
            unique case (s_hi)
              2'd0:    hi_byte = slot0_r[k];
              2'd1:    hi_byte = slot1_r[k];
              default: hi_byte = 8'h00;
            endcase
            pair         = {hi_byte, lo_byte} >> bit_offset_r;
            frame_nxt[k] = pair[7:0];
          end
          bit_offset_nxt = bit_offset_r + 3'd1;
          if (bit_offset_r == 3'd7) begin
            slot_index_nxt = (si_inc == SLOT_WRAP) ? 2'd0 : si_inc;
          end
        end
      end
      CMD_SCAN: begin
        res.column_drive = ~(8'h01 << scan_col_r);
        res.row_drive    = frame_r[scan_col_r];
        scan_col_nxt     = scan_col_r + 3'd1;
      end
      default: ;
    endcase

    res.going_down = arrow_down_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_floor_r  <= FLOOR_RESET;
      tick_count_r <= '0;
      bit_offset_r <= '0;
      slot_index_r <= '0;
      scan_col_r   <= '0;
      arrow_down_r <= 1'b0;
      slot0_r      <= '{default: '0};
      slot1_r      <= '{default: '0};
      frame_r      <= '{default: '0};
    end else if (fire) begin
      cur_floor_r  <= cur_floor_nxt;
      tick_count_r <= tick_count_nxt;
      bit_offset_r <= bit_offset_nxt;
      slot_index_r <= slot_index_nxt;
      scan_col_r   <= scan_col_nxt;
      arrow_down_r <= arrow_down_nxt;
      slot0_r      <= slot0_nxt;
      slot1_r      <= slot1_nxt;
      frame_r      <= frame_nxt;
    end
  end

endmodule
